/* rtl/bfe_pkg.sv */
package bfe_pkg;

   localparam logic [63:0] GOLDEN_ADD = 64'h0000_0000_9e37_79b9;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_INSERT,
      ST_QUERY,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_QUERY  = 1'b1
   } func_type;

endpackage

/* rtl/bloom_filter_engine.sv */
// Bloom filter engine over a single-port bit store of TABLE_BITS cells.
// The req channel carries one beat per operation: req_func selects insert
// or query and req_key is the signed 32-bit key. An insert sets the
// NUM_HASHES hashed cells and returns nothing. A query returns one beat on
// the rsp channel whose rsp_maybe_present is 1 when every hashed cell is set.
// The hash base is computed once per key in the hash state, then one cell is
// visited per cycle through the single memory port, so the port sets the
// rate. An insert passes through the hash and insert states, a query through
// the hash, query, drain and done states. req_ready is low while an
// operation is in progress. After reset the store is cleared one cell per
// cycle, so req_ready stays low until every cell has been cleared.
// The response sits in an output register. Inserts keep being taken while
// it waits; a query that finishes while the receiver stalls holds in its
// final state until the waiting beat is taken. The user must keep
// TABLE_BITS a power of two; the block itself does not enforce it.
module bloom_filter_engine #(
   parameter int NUM_HASHES = 4,
   parameter int TABLE_BITS = 8192
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_func,
   input  logic signed [31:0] req_key,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_maybe_present
);
   import bfe_pkg::*;

   localparam int IDX_W = $clog2(TABLE_BITS);
   localparam int S_W   = IDX_W + 2;
   localparam int K_W   = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;

   state_type state_ff, state_in;
   logic [S_W-1:0]   s1_ff, s1_in;
   logic [IDX_W-1:0] c_ff, c_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic             chk_ff, chk_in;
   logic             all_ff, all_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_bit_ff, rsp_bit_in;
   logic             rd_ff;

   logic             mem [TABLE_BITS];
   logic             mem_we;
   logic             mem_wd;
   logic [IDX_W-1:0] mem_addr;
   logic [IDX_W-1:0] hash_idx;
   logic             accept;
   logic             last_k;
   logic             rsp_free;

   assign accept   = req_valid && req_ready;
   assign last_k   = (k_ff == K_W'(NUM_HASHES - 1));
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign hash_idx = s1_ff[IDX_W-1:0] ^ (c_ff + IDX_W'(k_ff));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == {IDX_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            state_in = (all_ff) ? ST_QUERY : ST_INSERT;
         end
         ST_INSERT: begin
            if (last_k) begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if (last_k) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      s1_in        = s1_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      clr_in       = clr_ff;
      chk_in       = 1'b0;
      all_in       = all_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_bit_in   = rsp_bit_ff;
      mem_we       = 1'b0;
      mem_wd       = 1'b1;
      mem_addr     = hash_idx;
      case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_wd   = 1'b0;
            mem_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            k_in      = '0;
            if (accept) begin
               s1_in  = S_W'(req_key[S_W-1:0]) + S_W'(GOLDEN_ADD);
               // The flag carries the operation until the hash cycle.
               all_in = (func_type'(req_func) == FUNC_QUERY);
            end
         end
         ST_HASH: begin
            c_in = IDX_W'(GOLDEN_ADD) + IDX_W'({s1_ff, 6'b0}) + s1_ff[IDX_W+1:2];
         end
         ST_INSERT: begin
            mem_we = 1'b1;
            k_in   = k_ff + 1'b1;
         end
         ST_QUERY: begin
            chk_in = 1'b1;
            k_in   = k_ff + 1'b1;
            if (chk_ff) begin
               all_in = all_ff && rd_ff;
            end
         end
         ST_DRAIN: begin
            all_in = all_ff && rd_ff;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = all_ff;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         k_ff         <= '0;
         chk_ff       <= 1'b0;
         all_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         k_ff         <= k_in;
         chk_ff       <= chk_in;
         all_ff       <= all_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff      <= s1_in;
      c_ff       <= c_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end
      rd_ff <= mem[mem_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_maybe_present = rsp_bit_ff;

endmodule

/* rtl/bfe_checker.sv */
module bfe_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_maybe_present
);

   // A reset starts the clearing pass, so no beat is taken right after it.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready high right after reset");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // Each operation passes through the hash state before req_ready returns, so a
   // request beat is never followed directly by another one.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high in the cycle after a request beat");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp_valid dropped before its beat was taken");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_maybe_present))
      else $error("rsp_maybe_present changed while stalled");

endmodule

bind bloom_filter_engine bfe_checker u_bfe_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_maybe_present (rsp_maybe_present)
);

/* sim/tb_bloom_filter_engine.sv */
`timescale 1ns / 100ps

module tb_bloom_filter_engine;
   import bfe_pkg::*;

   localparam int NUM_HASHES = 4;
   localparam int TABLE_BITS = 8192;
   localparam int RANDOM_ITEMS = 1932;
   localparam int WATCHDOG_LIMIT = 50000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      func_type    op;
      logic [31:0] key;
      logic        pinned;
      logic        answer;
   } probe_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_func;
   logic signed [31:0] req_key;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_maybe_present;

   logic row_pinned;
   logic row_answer;

   bit [TABLE_BITS-1:0] cells_set = '0;
   bit answers_due[$];
   logic [31:0] stored_keys[$];
   probe_row_type directed_rows[18];

   int mismatches = 0;
   int idle_cycles;
   int reqs_taken = 0;
   int inserts_seen = 0;
   int queries_seen = 0;
   int present_seen = 0;
   int absent_seen = 0;
   bit held_once;

   bloom_filter_engine #(
      .NUM_HASHES(NUM_HASHES),
      .TABLE_BITS(TABLE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_key(req_key),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_maybe_present(rsp_maybe_present)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned cell_index(logic [31:0] key, int unsigned hash_no);
      logic [63:0] acc;
      acc = {{32{key[31]}}, key} + GOLDEN_ADD;
      acc = acc ^ (64'(hash_no) + GOLDEN_ADD + (acc << 6) + (acc >> 2));
      return int'(acc % 64'(TABLE_BITS));
   endfunction

   function automatic bit cells_all_set(logic [31:0] key);
      for (int n = 0; n < NUM_HASHES; n++) begin
         if (!cells_set[cell_index(key, n)])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit no_idle_phase();
      return reqs_taken >= 1000 && reqs_taken < 1200;
   endfunction

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle_phase())
         return 0;
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] fresh_key();
      int r;
      logic [31:0] k;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         k = $urandom_range(0, 16) - 8;
      end else if (r < 15) begin
         case ($urandom_range(0, 6))
            0: k = 32'h8000_0000;
            1: k = 32'h7fff_ffff;
            2: k = 32'hffff_ffff;
            3: k = 32'h0000_0000;
            4: k = 32'h0000_0001;
            5: k = 32'h8000_0001;
            default: k = 32'h7fff_fffe;
         endcase
      end else if (r < 20) begin
         k = 32'h1 << $urandom_range(0, 31);
         if ($urandom_range(0, 1))
            k = ~k;
      end else begin
         k = $urandom;
      end
      return k;
   endfunction

   task automatic send_beat(input func_type op, input logic [31:0] key, input logic pinned,
                            input logic answer);
      int gap;
      gap = pick_idle();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_func = op;
      req_key = key;
      row_pinned = pinned;
      row_answer = answer;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      bit predicted;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            reqs_taken <= reqs_taken + 1;
            if (req_func == FUNC_INSERT) begin
               inserts_seen <= inserts_seen + 1;
               for (int n = 0; n < NUM_HASHES; n++)
                  cells_set[cell_index(req_key, n)] = 1'b1;
            end else begin
               queries_seen <= queries_seen + 1;
               predicted = row_pinned ? row_answer : cells_all_set(req_key);
               answers_due = {answers_due, predicted};
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $error("rsp beat arrived with no query outstanding");
               mismatches <= mismatches + 1;
            end else begin
               predicted = answers_due.pop_front();
               if (rsp_maybe_present !== predicted) begin
                  $error("maybe_present: expected %0b, got %0b", predicted, rsp_maybe_present);
                  mismatches <= mismatches + 1;
               end
               if (predicted)
                  present_seen <= present_seen + 1;
               else
                  absent_seen <= absent_seen + 1;
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d cycles without a beat", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      held_once = 1'b0;
      stall = 0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (!held_once && present_seen + absent_seen >= 150) begin
            held_once = 1'b1;
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (stall > 0) begin
            rsp_ready = 1'b0;
            stall = stall - 1;
            @(negedge clock);
         end else begin
            stall = pick_idle();
            rsp_ready = (stall == 0);
            @(negedge clock);
         end
      end
   end

   initial begin
      int r;
      int missing;
      func_type op;
      logic [31:0] key;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_INSERT;
      req_key = '0;
      row_pinned = 1'b0;
      row_answer = 1'b0;
      directed_rows = '{
         '{FUNC_QUERY,  32'h0000_0000, 1'b1, 1'b0},
         '{FUNC_QUERY,  32'h8000_0000, 1'b1, 1'b0},
         '{FUNC_QUERY,  32'h7fff_ffff, 1'b1, 1'b0},
         '{FUNC_QUERY,  32'hffff_ffff, 1'b1, 1'b0},
         '{FUNC_INSERT, 32'h0000_0000, 1'b0, 1'b0},
         '{FUNC_QUERY,  32'h0000_0000, 1'b1, 1'b1},
         '{FUNC_INSERT, 32'h0000_0000, 1'b0, 1'b0},
         '{FUNC_QUERY,  32'h0000_0000, 1'b1, 1'b1},
         '{FUNC_INSERT, 32'h8000_0000, 1'b0, 1'b0},
         '{FUNC_QUERY,  32'h8000_0000, 1'b1, 1'b1},
         '{FUNC_INSERT, 32'h7fff_ffff, 1'b0, 1'b0},
         '{FUNC_QUERY,  32'h7fff_ffff, 1'b1, 1'b1},
         '{FUNC_INSERT, 32'hffff_ffff, 1'b0, 1'b0},
         '{FUNC_QUERY,  32'hffff_ffff, 1'b1, 1'b1},
         '{FUNC_QUERY,  32'h0000_0001, 1'b0, 1'b0},
         '{FUNC_INSERT, 32'haaaa_aaaa, 1'b0, 1'b0},
         '{FUNC_QUERY,  32'haaaa_aaaa, 1'b1, 1'b1},
         '{FUNC_QUERY,  32'h5555_5555, 1'b0, 1'b0}
      };
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == FUNC_INSERT)
            stored_keys = {stored_keys, directed_rows[i].key};
         send_beat(directed_rows[i].op, directed_rows[i].key, directed_rows[i].pinned,
                   directed_rows[i].answer);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            op = FUNC_INSERT;
            key = fresh_key();
            stored_keys = {stored_keys, key};
         end else if (r < 50) begin
            op = FUNC_INSERT;
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
         end else if (r < 75) begin
            op = FUNC_QUERY;
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
         end else begin
            op = FUNC_QUERY;
            key = fresh_key();
         end
         send_beat(op, key, 1'b0, 1'b0);
      end
      req_valid = 1'b0;

      while (answers_due.size() != 0)
         @(posedge clock);
      repeat (NUM_HASHES + 8) @(posedge clock);
      missing = answers_due.size();
      if (missing != 0)
         $error("%0d query answers never arrived", missing);

      $display("Sent %0d inserts and %0d queries with random gaps and one long receiver hold.",
               inserts_seen, queries_seen);
      $display("Queries answered: %0d maybe present, %0d absent.", present_seen, absent_seen);
      if (mismatches == 0 && missing == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
